// ----- rtl/qrv_pkg.sv -----
// Package: payload types, pipeline constants and fixed-point helpers for the rotation unit.
`default_nettype none
package qrv_pkg;

   localparam int unsigned DivSteps = 33;           // quotient bits of 2^32 / norm
   localparam int unsigned DivLat   = DivSteps;     // one restoring step per stage
   localparam int unsigned NStages  = DivLat + 7;

   typedef struct packed {
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic signed [31:0] quat_w;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_x;
      logic signed [31:0] rot_y;
      logic signed [31:0] rot_z;
      logic               zero_norm;
   } rsp_type;

   typedef logic signed [31:0] q16_type;

   // 32x32 signed product, arithmetic shift right 16, wrap to 32 bits
   function automatic q16_type qmul(input q16_type a, input q16_type b);
      logic signed [63:0] p;
      begin
         p = 64'(a) * 64'(b);
         qmul = q16_type'(p >>> 16);
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_rotate_vector_q16_unit.sv -----
// Top level: pipelined quaternion rotation of a Q16.16 vector.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | qrv_pkg::req_type
//  rsp_    | out       | rsp_valid/rsp_ready  | qrv_pkg::rsp_type
//
// One item per cycle while the output is not stalled; the pipe holds the 33-step restoring divider
// (one quotient bit per stage) plus squares, norm, inverse and two product/sum pairs.
// The whole pipe advances when its last stage is empty or being taken; a stall
// freezes every stage. Reset clears the valid bits only.
`default_nettype none
module quaternion_rotate_vector_q16_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire qrv_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output qrv_pkg::rsp_type       rsp_data
);
   import qrv_pkg::*;

   logic adv;
   logic [NStages-1:0] vld_ff, vld_in;

   assign adv       = !vld_ff[NStages-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NStages-1];

   always_comb begin
      vld_in = {vld_ff[NStages-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: capture item, four squares
   req_type s0_ff;
   q16_type sq_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff    <= req_data;
         sq_ff[0] <= qmul(req_data.quat_x, req_data.quat_x);
         sq_ff[1] <= qmul(req_data.quat_y, req_data.quat_y);
         sq_ff[2] <= qmul(req_data.quat_z, req_data.quat_z);
         sq_ff[3] <= qmul(req_data.quat_w, req_data.quat_w);
      end
   end

   // stage 1: norm, sign and magnitude for the divider
   req_type s1_ff;
   logic    zn_s1_ff, neg_s1_ff;
   logic [31:0] mag_s1_ff;
   q16_type norm_in;
   assign norm_in = sq_ff[0] + sq_ff[1] + sq_ff[2] + sq_ff[3];
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff     <= s0_ff;
         zn_s1_ff  <= (norm_in == '0);
         neg_s1_ff <= norm_in[31];
         mag_s1_ff <= norm_in[31] ? 32'(-norm_in) : 32'(norm_in);
      end
   end

   // divider stages: restoring division of 2^32 by mag, MSB first
   req_type     dv_q_ff   [DivLat];
   logic        dv_zn_ff  [DivLat];
   logic        dv_neg_ff [DivLat];
   logic [31:0] dv_mag_ff [DivLat];
   logic [32:0] dv_rem_ff [DivLat];
   logic [32:0] dv_quo_ff [DivLat];

   for (genvar i = 0; i < DivLat; i++) begin : g_div
      logic [32:0] rem_prev, quo_prev, trial, rem_nx, quo_nx;
      logic [32:0] dvd;
      logic [31:0] mag_prev;
      req_type     q_prev;
      logic        zn_prev, neg_prev, bit_in;
      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign mag_prev = mag_s1_ff;
         assign q_prev   = s1_ff;
         assign zn_prev  = zn_s1_ff;
         assign neg_prev = neg_s1_ff;
      end else begin : g_next
         assign rem_prev = dv_rem_ff[i-1];
         assign quo_prev = dv_quo_ff[i-1];
         assign mag_prev = dv_mag_ff[i-1];
         assign q_prev   = dv_q_ff[i-1];
         assign zn_prev  = dv_zn_ff[i-1];
         assign neg_prev = dv_neg_ff[i-1];
      end
      always_comb begin
         dvd    = 33'h1_0000_0000;
         bit_in = dvd[DivSteps-1-i];
         trial  = {rem_prev[31:0], bit_in};
         if (trial >= {1'b0, mag_prev}) begin
            rem_nx = trial - {1'b0, mag_prev};
            quo_nx = {quo_prev[31:0], 1'b1};
         end else begin
            rem_nx = trial;
            quo_nx = {quo_prev[31:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[i] <= rem_nx;
            dv_quo_ff[i] <= quo_nx;
            dv_q_ff[i]   <= q_prev;
            dv_zn_ff[i]  <= zn_prev;
            dv_neg_ff[i] <= neg_prev;
            dv_mag_ff[i] <= mag_prev;
         end
      end
   end

   // sign fix: len wraps to 32 bits; zero norm gives a harmless quotient
   localparam int unsigned DL = DivLat - 1;
   q16_type len_w;
   assign len_w = dv_neg_ff[DL] ? q16_type'(-dv_quo_ff[DL][31:0])
                                : q16_type'(dv_quo_ff[DL][31:0]);

   // stage I: inverse quaternion
   req_type si_ff;
   logic    zn_si_ff;
   q16_type inv_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         si_ff     <= dv_q_ff[DL];
         zn_si_ff  <= dv_zn_ff[DL];
         inv_ff[0] <= qmul(dv_q_ff[DL].quat_x, -len_w);
         inv_ff[1] <= qmul(dv_q_ff[DL].quat_y, -len_w);
         inv_ff[2] <= qmul(dv_q_ff[DL].quat_z, -len_w);
         inv_ff[3] <= qmul(dv_q_ff[DL].quat_w, len_w);
      end
   end

   // stage T1: products of v (w = 0) and inverse
   req_type st1_ff;
   logic    zn_st1_ff;
   q16_type tp_ff [12];
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff    <= si_ff;
         zn_st1_ff <= zn_si_ff;
         tp_ff[0]  <= qmul(si_ff.vec_x, inv_ff[3]);
         tp_ff[1]  <= qmul(si_ff.vec_y, inv_ff[2]);
         tp_ff[2]  <= qmul(si_ff.vec_z, inv_ff[1]);
         tp_ff[3]  <= qmul(si_ff.vec_x, inv_ff[2]);
         tp_ff[4]  <= qmul(si_ff.vec_y, inv_ff[3]);
         tp_ff[5]  <= qmul(si_ff.vec_z, inv_ff[0]);
         tp_ff[6]  <= qmul(si_ff.vec_x, inv_ff[1]);
         tp_ff[7]  <= qmul(si_ff.vec_y, inv_ff[0]);
         tp_ff[8]  <= qmul(si_ff.vec_z, inv_ff[3]);
         tp_ff[9]  <= qmul(si_ff.vec_x, inv_ff[0]);
         tp_ff[10] <= qmul(si_ff.vec_y, inv_ff[1]);
         tp_ff[11] <= qmul(si_ff.vec_z, inv_ff[2]);
      end
   end

   // stage T2: sums giving t = v * inv
   req_type st2_ff;
   logic    zn_st2_ff;
   q16_type t_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         st2_ff    <= st1_ff;
         zn_st2_ff <= zn_st1_ff;
         t_ff[0]   <= tp_ff[0] + tp_ff[1] - tp_ff[2];
         t_ff[1]   <= -tp_ff[3] + tp_ff[4] + tp_ff[5];
         t_ff[2]   <= tp_ff[6] - tp_ff[7] + tp_ff[8];
         t_ff[3]   <= -tp_ff[9] - tp_ff[10] - tp_ff[11];
      end
   end

   // stage R1: products of q and t (vector part only)
   logic    zn_r1_ff;
   q16_type rp_ff [12];
   always_ff @(posedge clock) begin
      if (adv) begin
         zn_r1_ff  <= zn_st2_ff;
         rp_ff[0]  <= qmul(st2_ff.quat_w, t_ff[0]);
         rp_ff[1]  <= qmul(st2_ff.quat_x, t_ff[3]);
         rp_ff[2]  <= qmul(st2_ff.quat_y, t_ff[2]);
         rp_ff[3]  <= qmul(st2_ff.quat_z, t_ff[1]);
         rp_ff[4]  <= qmul(st2_ff.quat_w, t_ff[1]);
         rp_ff[5]  <= qmul(st2_ff.quat_x, t_ff[2]);
         rp_ff[6]  <= qmul(st2_ff.quat_y, t_ff[3]);
         rp_ff[7]  <= qmul(st2_ff.quat_z, t_ff[0]);
         rp_ff[8]  <= qmul(st2_ff.quat_w, t_ff[2]);
         rp_ff[9]  <= qmul(st2_ff.quat_x, t_ff[1]);
         rp_ff[10] <= qmul(st2_ff.quat_y, t_ff[0]);
         rp_ff[11] <= qmul(st2_ff.quat_z, t_ff[3]);
      end
   end

   // stage R2: final sums, zero-norm override; output register
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.zero_norm <= zn_r1_ff;
         if (zn_r1_ff) begin
            out_ff.rot_x <= '0;
            out_ff.rot_y <= '0;
            out_ff.rot_z <= '0;
         end else begin
            out_ff.rot_x <= rp_ff[0] + rp_ff[1] + rp_ff[2] - rp_ff[3];
            out_ff.rot_y <= rp_ff[4] - rp_ff[5] + rp_ff[6] + rp_ff[7];
            out_ff.rot_z <= rp_ff[8] + rp_ff[9] - rp_ff[10] + rp_ff[11];
         end
      end
   end

   assign rsp_data = out_ff;

endmodule
`default_nettype wire

// ----- tb/tb_quaternion_rotate_vector_q16_unit.sv -----
// Testbench: random and directed quaternion rotations checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_quaternion_rotate_vector_q16_unit;
   import qrv_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   quaternion_rotate_vector_q16_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type pending_items[$];
   rsp_type expected_rots[$];
   int      mismatches = 0;
   int      send_idle_pct = 6;
   int      recv_idle_pct = 81;

   typedef logic signed [31:0] fx_type;
   typedef struct {fx_type x, y, z, w;} quat4_type;

   function automatic fx_type fx_mul(fx_type a, fx_type b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return fx_type'(p >>> 16);
   endfunction

   function automatic quat4_type hamilton(quat4_type a, quat4_type b);
      quat4_type r;
      r.x = fx_mul(a.w, b.x) + fx_mul(a.x, b.w) + fx_mul(a.y, b.z) - fx_mul(a.z, b.y);
      r.y = fx_mul(a.w, b.y) - fx_mul(a.x, b.z) + fx_mul(a.y, b.w) + fx_mul(a.z, b.x);
      r.z = fx_mul(a.w, b.z) + fx_mul(a.x, b.y) - fx_mul(a.y, b.x) + fx_mul(a.z, b.w);
      r.w = fx_mul(a.w, b.w) - fx_mul(a.x, b.x) - fx_mul(a.y, b.y) - fx_mul(a.z, b.z);
      return r;
   endfunction

   function automatic rsp_type rotate_vector(req_type it);
      quat4_type q, v, inv, r;
      fx_type norm, len, nlen;
      logic signed [63:0] quo;
      rsp_type o;
      q = '{it.quat_x, it.quat_y, it.quat_z, it.quat_w};
      v = '{it.vec_x, it.vec_y, it.vec_z, 32'sd0};
      norm = fx_mul(q.x, q.x) + fx_mul(q.y, q.y) + fx_mul(q.z, q.z) + fx_mul(q.w, q.w);
      o = '0;
      if (norm == 0) begin
         o.zero_norm = 1'b1;
         return o;
      end
      quo = 64'sh1_0000_0000 / 64'(norm);   // truncates toward zero
      len = fx_type'(quo);
      nlen = -len;
      inv = '{fx_mul(q.x, nlen), fx_mul(q.y, nlen), fx_mul(q.z, nlen), fx_mul(q.w, len)};
      r = hamilton(q, hamilton(v, inv));
      o.rot_x = r.x;
      o.rot_y = r.y;
      o.rot_z = r.z;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   function automatic fx_type rand_fx();
      case ($urandom_range(0, 5))
         0: return fx_type'($urandom);
         1: return fx_type'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
         2: return fx_type'($urandom_range(0, 32'h0000_0200)) - 32'sh0000_0100;
         3: return fx_type'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         4: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return fx_type'($urandom_range(0, 32'h0000_b505)) * (($urandom & 1) ? 1 : -1);
      endcase
   endfunction

   function automatic req_type make_item(fx_type qx, fx_type qy, fx_type qz, fx_type qw,
                                         fx_type vx, fx_type vy, fx_type vz);
      req_type it;
      it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
      it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
      return it;
   endfunction

   // acceptance seen at the rising edge, used by the driver on the falling edge
   logic req_ready_q = 1'b0;
   always @(posedge clock) begin
      req_ready_q <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_rots.push_back(rotate_vector(req_data));
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_q) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rots.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.rot_x, 32'h0);
         end else begin
            want = expected_rots.pop_front();
            if (rsp_data.rot_x !== want.rot_x) report_mismatch("rot_x", rsp_data.rot_x, want.rot_x);
            if (rsp_data.rot_y !== want.rot_y) report_mismatch("rot_y", rsp_data.rot_y, want.rot_y);
            if (rsp_data.rot_z !== want.rot_z) report_mismatch("rot_z", rsp_data.rot_z, want.rot_z);
            if (rsp_data.zero_norm !== want.zero_norm)
               report_mismatch("zero_norm", 32'(rsp_data.zero_norm), 32'(want.zero_norm));
         end
      end
   end

   initial begin
      fx_type one, mx, mn;
      one = 32'sh0001_0000; mx = 32'sh7fff_ffff; mn = 32'sh8000_0000;
      // directed: identity, zero quaternion, axis turns, extremes, all -1 LSB inputs (norm of zero), tiny norm
      pending_items.push_back(make_item(0, 0, 0, one, one, 2 * one, -3 * one));
      pending_items.push_back(make_item(0, 0, 0, 0, one, one, one));
      pending_items.push_back(make_item(32'sh0000_b505, 0, 0, 32'sh0000_b505, 0, one, 0));
      pending_items.push_back(make_item(0, 32'sh0000_b505, 0, 32'sh0000_b505, one, 0, 0));
      pending_items.push_back(make_item(0, 0, one, 0, one, one, 0));
      pending_items.push_back(make_item(mx, mx, mx, mx, mx, mx, mx));
      pending_items.push_back(make_item(mn, mn, mn, mn, mn, mn, mn));
      pending_items.push_back(make_item(mn, 0, 0, 0, mx, mn, one));
      pending_items.push_back(make_item(0, 0, 0, 32'sh0000_0100, one, -one, one));
      pending_items.push_back(make_item(0, 0, 0, 32'sh0000_00ff, one, one, one));
      pending_items.push_back(make_item(0, 0, 0, 32'sh0100_0000, one, 0, 0));
      pending_items.push_back(make_item(-1, -1, -1, -1, -1, -1, -1));
      pending_items.push_back(make_item(0, 0, 0, 32'sh0000_b505, mx, mn, 0));
      pending_items.push_back(make_item(one, one, one, one, mn, mx, -one));
      pending_items.push_back(make_item(0, 0, 0, 32'sh0001_6a0a, one, 0, 0));
      pending_items.push_back(make_item(0, 0, 0, 32'sh8000_0000, 0, 0, one));
      repeat (6) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 81; recv_idle_pct = 6; end
         if (ph == 2) begin send_idle_pct = 0;  recv_idle_pct = 0; end
         for (int i = 0; i < 430; i++)
            pending_items.push_back(make_item(rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                                              rand_fx(), rand_fx(), rand_fx()));
         wait (pending_items.size() == 0 && !req_valid);
         // a stretch with no idle cycles after each phase but the last
         if (ph != 2) begin
            send_idle_pct = 0; recv_idle_pct = 0;
            for (int i = 0; i < 30; i++)
               pending_items.push_back(make_item(rand_fx(), rand_fx(), rand_fx(), rand_fx(),
                                                 rand_fx(), rand_fx(), rand_fx()));
            wait (pending_items.size() == 0 && !req_valid);
         end
      end
      wait (expected_rots.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_rots.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
